// ----- rtl/eqsf_pkg.sv -----
// Package: constants, control types and microcode ROM of the quarter-ellipse span filler.
package eqsf_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int SPAN_BUDGET   = 64;

  localparam int CW    = 12;                        // span geometry arithmetic
  localparam int SW    = 24;                        // decision value
  localparam int N_W   = $clog2(SPAN_BUDGET + 1);
  localparam int UPC_W = 4;

  localparam logic signed [CW-1:0] SCR_W = CW'(SCREEN_WIDTH);
  localparam logic signed [CW-1:0] SCR_H = CW'(SCREEN_HEIGHT);

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_SQUARE,
    OP_INIT,
    OP_LOOP,
    OP_UPD,
    OP_FIN
  } op_t;

  typedef enum logic [2:0] {
    J_NONE,
    J_ALWAYS,
    J_NOSTART,
    J_SMALL,
    J_FAIL
  } jmp_t;

  typedef struct packed {
    op_t  op;
    logic region;
    jmp_t jmp;
    upc_t target;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic region;
  } ctrl_t;

  typedef struct packed {
    logic tiny;
    logic fail;
  } stat_t;

  localparam upc_t A_IDLE   = upc_t'(0);
  localparam upc_t A_SQUARE = upc_t'(1);
  localparam upc_t A_INIT1  = upc_t'(2);
  localparam upc_t A_LOOP1  = upc_t'(3);
  localparam upc_t A_UPD1   = upc_t'(4);
  localparam upc_t A_INIT2  = upc_t'(5);
  localparam upc_t A_LOOP2  = upc_t'(6);
  localparam upc_t A_UPD2   = upc_t'(7);
  localparam upc_t A_FIN    = upc_t'(8);

  // region 0 steps x, region 1 steps y
  function automatic uword_t ucode(input upc_t a);
    uword_t w;
    unique case (a)
      A_IDLE:   w = '{op: OP_IDLE,   region: 1'b0, jmp: J_NOSTART, target: A_IDLE};
      A_SQUARE: w = '{op: OP_SQUARE, region: 1'b0, jmp: J_SMALL,   target: A_FIN};
      A_INIT1:  w = '{op: OP_INIT,   region: 1'b0, jmp: J_NONE,    target: A_IDLE};
      A_LOOP1:  w = '{op: OP_LOOP,   region: 1'b0, jmp: J_FAIL,    target: A_INIT2};
      A_UPD1:   w = '{op: OP_UPD,    region: 1'b0, jmp: J_ALWAYS,  target: A_LOOP1};
      A_INIT2:  w = '{op: OP_INIT,   region: 1'b1, jmp: J_NONE,    target: A_IDLE};
      A_LOOP2:  w = '{op: OP_LOOP,   region: 1'b1, jmp: J_FAIL,    target: A_FIN};
      A_UPD2:   w = '{op: OP_UPD,    region: 1'b1, jmp: J_ALWAYS,  target: A_LOOP2};
      A_FIN:    w = '{op: OP_FIN,    region: 1'b0, jmp: J_ALWAYS,  target: A_IDLE};
      default:  w = '{op: OP_IDLE,   region: 1'b0, jmp: J_ALWAYS,  target: A_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/eqsf_seq.sv -----
// Microcode sequencer: step counter, control ROM and jump logic.
module eqsf_seq import eqsf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output ctrl_t ctrl,
  output logic  busy
);

  upc_t   upc, upc_next;
  uword_t w;
  logic   taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= A_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  always_comb begin
    w = ucode(upc);
    unique case (w.jmp)
      J_NONE:    taken = 1'b0;
      J_ALWAYS:  taken = 1'b1;
      J_NOSTART: taken = !start;
      J_SMALL:   taken = stat.tiny;
      J_FAIL:    taken = stat.fail;
      default:   taken = 1'b1;
    endcase
    upc_next = taken ? w.target : upc + 1'b1;
  end

  assign ctrl = '{op: w.op, region: w.region};
  assign busy = (w.op != OP_IDLE);

endmodule

// ----- rtl/eqsf_dp.sv -----
// Datapath: radii squares, midpoint decision value, span clipping and output word.
module eqsf_dp import eqsf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ctrl_t              ctrl,
  input  logic [1:0]         corner,
  input  logic signed [9:0]  anchor_x,
  input  logic signed [9:0]  anchor_y,
  input  logic [4:0]         radius_x,
  input  logic [4:0]         radius_y,
  output stat_t              stat,
  output logic               span_strobe,
  output logic signed [10:0] span_row,
  output logic [6:0]         span_start,
  output logic [7:0]         span_length,
  output logic               last_span
);

  logic [1:0]         crn;
  logic signed [9:0]  ax, ay;
  logic [4:0]         rx, ry;
  logic [9:0]         rx2, ry2;
  logic [5:0]         u, v;
  logic signed [SW-1:0] s, ta, tb;
  logic [N_W-1:0]     n;

  logic               pend_valid;
  logic signed [10:0] pend_row;
  logic [6:0]         pend_start;
  logic [7:0]         pend_len;

  // u steps, v moves; P weighs u, Q weighs v
  logic [9:0]         p, q;
  logic [4:0]         r;
  logic [15:0]        prod_u, prod_v;
  logic               fail;
  logic signed [SW-1:0] s_init, s_next, ta_c, tb_c, p_e, q_e;

  logic [5:0]         px, py;
  logic signed [CW-1:0] x_e, y_e, ax_e, ay_e, row_c, xs_c, lo_c, hi_c, vis_c;
  logic               shown;

  assign p = ctrl.region ? rx2 : ry2;
  assign q = ctrl.region ? ry2 : rx2;
  assign r = ctrl.region ? rx : ry;

  assign prod_u = {6'b0, p} * {10'b0, u};
  assign prod_v = {6'b0, q} * {10'b0, v};
  assign fail   = (n == N_W'(SPAN_BUDGET)) || (prod_u > prod_v);

  assign p_e    = $signed({{(SW-10){1'b0}}, p});
  assign q_e    = $signed({{(SW-10){1'b0}}, q});
  assign s_init = (p_e <<< 1)
                + q_e * ($signed(SW'(1)) - $signed({{(SW-6){1'b0}}, r, 1'b0}));
  assign ta_c   = (q_e <<< 2) * ($signed(SW'(1)) - $signed({{(SW-6){1'b0}}, v}));
  assign tb_c   = p_e * ($signed({{(SW-8){1'b0}}, u, 2'b00}) + $signed(SW'(6)));
  assign s_next = s + (s[SW-1] ? '0 : ta) + tb;

  assign stat = '{tiny: (rx < 5'd2) || (ry < 5'd2), fail: fail};

  // span geometry and clip
  assign px    = ctrl.region ? v : u;
  assign py    = ctrl.region ? u : v;
  assign x_e   = $signed({{(CW-6){1'b0}}, px});
  assign y_e   = $signed({{(CW-6){1'b0}}, py});
  assign ax_e  = CW'(ax);
  assign ay_e  = CW'(ay);
  assign row_c = crn[1] ? ay_e + y_e - $signed(CW'(1)) : ay_e - y_e;
  assign xs_c  = crn[0] ? ax_e - x_e : ax_e;
  assign lo_c  = xs_c[CW-1] ? '0 : xs_c;
  assign hi_c  = (xs_c + x_e > SCR_W) ? SCR_W : xs_c + x_e;
  assign shown = !row_c[CW-1] && (row_c < SCR_H) && (hi_c > lo_c);
  assign vis_c = hi_c - lo_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      span_strobe <= 1'b0;
      pend_valid  <= 1'b0;
      n           <= '0;
    end else begin
      span_strobe <= 1'b0;
      unique case (ctrl.op)
        OP_SQUARE: begin
          pend_valid <= 1'b0;
          n          <= '0;
        end
        OP_LOOP: if (!fail) begin
          span_strobe <= pend_valid;
          pend_valid  <= 1'b1;
          n           <= n + 1'b1;
        end
        OP_FIN:  span_strobe <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_IDLE: if (start) begin
        crn <= corner;
        ax  <= anchor_x;
        ay  <= anchor_y;
        rx  <= radius_x;
        ry  <= radius_y;
      end
      OP_SQUARE: begin
        rx2 <= {5'b0, rx} * {5'b0, rx};
        ry2 <= {5'b0, ry} * {5'b0, ry};
      end
      OP_INIT: begin
        u <= '0;
        v <= {1'b0, r};
        s <= s_init;
      end
      OP_LOOP: if (!fail) begin
        span_row    <= pend_row;
        span_start  <= pend_start;
        span_length <= pend_len;
        last_span   <= 1'b0;
        pend_row    <= row_c[10:0];
        pend_start  <= shown ? lo_c[6:0] : '0;
        pend_len    <= shown ? vis_c[7:0] : '0;
        ta          <= ta_c;
        tb          <= tb_c;
      end
      OP_UPD: begin
        s <= s_next;
        u <= u + 1'b1;
        if (!s[SW-1]) v <= v - 1'b1;
      end
      OP_FIN: begin
        span_row    <= pend_valid ? pend_row : '0;
        span_start  <= pend_valid ? pend_start : '0;
        span_length <= pend_valid ? pend_len : '0;
        last_span   <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/ellipse_quadrant_span_fill.sv -----
// Quarter-ellipse span filler: clipped midpoint spans for one corner per command.
// Busy is high from the accepting edge through the square, init, test/update and
// finish steps, with at most 64 loop iterations; the last span word appears in the
// cycle busy drops. Each word is one cycle long; one span comes per test/update step
// pair in a region, with the failing test and second init step between the regions. A
// new command is taken in the cycle the last word shows. Reset: idle, no pending word.
module ellipse_quadrant_span_fill import eqsf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         corner,
  input  logic signed [9:0]  anchor_x,
  input  logic signed [9:0]  anchor_y,
  input  logic [4:0]         radius_x,
  input  logic [4:0]         radius_y,
  output logic               span_strobe,
  output logic signed [10:0] span_row,
  output logic [6:0]         span_start,
  output logic [7:0]         span_length,
  output logic               last_span
);

  ctrl_t ctrl;
  stat_t stat;

  eqsf_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  eqsf_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .ctrl        (ctrl),
    .corner      (corner),
    .anchor_x    (anchor_x),
    .anchor_y    (anchor_y),
    .radius_x    (radius_x),
    .radius_y    (radius_y),
    .stat        (stat),
    .span_strobe (span_strobe),
    .span_row    (span_row),
    .span_start  (span_start),
    .span_length (span_length),
    .last_span   (last_span)
  );

  a_done_with_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> span_strobe && last_span)
    else $error("busy dropped without a last span word");

  a_mid_word_busy: assert property (@(posedge clk) disable iff (rst)
    span_strobe && !last_span |-> busy)
    else $error("non-final span word outside a command");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

endmodule

// ----- dv/span_word_checker.sv -----
// Checker: predicts the span words of each accepted command and compares them as they leave.
module span_word_checker import eqsf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         corner,
  input  logic signed [9:0]  anchor_x,
  input  logic signed [9:0]  anchor_y,
  input  logic [4:0]         radius_x,
  input  logic [4:0]         radius_y,
  input  logic               span_strobe,
  input  logic signed [10:0] span_row,
  input  logic [6:0]         span_start,
  input  logic [7:0]         span_length,
  input  logic               last_span,
  output int                 fails,
  output int                 waiting,
  output int                 words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEFT_BIT   = 0;
  localparam int BOTTOM_BIT = 1;
  localparam int MIN_RADIUS = 2;

  typedef struct packed {
    logic signed [10:0] row;
    logic [6:0]         col;
    logic [7:0]         len;
    logic               last;
  } span_word_t;

  span_word_t span_q[$];

  initial begin
    fails = 0;
    waiting = 0;
    words_checked = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] span word mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  // clip one unclipped span to the screen
  function automatic span_word_t clip_span(input int row, input int xs, input int len);
    span_word_t w;
    int lo;
    int hi;
    lo = (xs < 0) ? 0 : xs;
    hi = (xs + len > SCREEN_WIDTH) ? SCREEN_WIDTH : xs + len;
    w.row  = 11'(row);
    w.col  = '0;
    w.len  = '0;
    w.last = 1'b0;
    if (row >= 0 && row < SCREEN_HEIGHT && hi > lo) begin
      w.col = 7'(lo);
      w.len = 8'(hi - lo);
    end
    return w;
  endfunction

  task automatic predict_quadrant(input logic [1:0] c, input int ax, input int ay,
                                  input int rx, input int ry);
    int rx2, ry2, x, y, d, n, row, xs;
    n = 0;
    if (rx < MIN_RADIUS || ry < MIN_RADIUS) begin
      span_q.push_back('{row: '0, col: '0, len: '0, last: 1'b1});
      return;
    end
    rx2 = rx * rx;
    ry2 = ry * ry;
    // region stepping x
    x = 0;
    y = ry;
    d = 2 * ry2 + rx2 * (1 - 2 * ry);
    while (n < SPAN_BUDGET && ry2 * x <= rx2 * y) begin
      row = c[BOTTOM_BIT] ? ay + y - 1 : ay - y;
      xs  = c[LEFT_BIT] ? ax - x : ax;
      span_q.push_back(clip_span(row, xs, x));
      n++;
      if (d >= 0) begin
        d += 4 * rx2 * (1 - y);
        y--;
      end
      d += ry2 * (4 * x + 6);
      x++;
    end
    // region stepping y
    x = rx;
    y = 0;
    d = 2 * rx2 + ry2 * (1 - 2 * rx);
    while (n < SPAN_BUDGET && rx2 * y <= ry2 * x) begin
      row = c[BOTTOM_BIT] ? ay + y - 1 : ay - y;
      xs  = c[LEFT_BIT] ? ax - x : ax;
      span_q.push_back(clip_span(row, xs, x));
      n++;
      if (d >= 0) begin
        d += 4 * ry2 * (1 - x);
        x--;
      end
      d += rx2 * (4 * y + 6);
      y++;
    end
    if (n == 0)
      span_q.push_back('{row: '0, col: '0, len: '0, last: 1'b1});
    else
      span_q[span_q.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    span_word_t w;
    if (!rst) begin
      if (span_strobe) begin
        words_checked++;
        if (span_q.size() == 0) begin
          $display("[%0t] span word with none expected", $realtime);
          fails++;
        end else begin
          w = span_q.pop_front();
          if (span_row !== w.row)
            report_mismatch("span_row", int'(span_row), int'(w.row));
          if (span_start !== w.col)
            report_mismatch("span_start", int'(span_start), int'(w.col));
          if (span_length !== w.len)
            report_mismatch("span_length", int'(span_length), int'(w.len));
          if (last_span !== w.last)
            report_mismatch("last_span", int'(last_span), int'(w.last));
        end
      end
      if (start && busy === 1'b0)
        predict_quadrant(corner, int'(anchor_x), int'(anchor_y),
                         int'(radius_x), int'(radius_y));
    end
    waiting = span_q.size();
  end

endmodule

// ----- dv/tb_ellipse_quadrant_span_fill.sv -----
// Testbench top: drives quarter-ellipse commands and gives the verdict from the checker.
module tb_ellipse_quadrant_span_fill;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_CMDS = 400;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [1:0]         corner = '0;
  logic signed [9:0]  anchor_x = '0;
  logic signed [9:0]  anchor_y = '0;
  logic [4:0]         radius_x = '0;
  logic [4:0]         radius_y = '0;
  logic               busy;
  logic               span_strobe;
  logic signed [10:0] span_row;
  logic [6:0]         span_start;
  logic [7:0]         span_length;
  logic               last_span;

  int  fails;
  int  waiting;
  int  words_checked;
  int  cmds_sent = 0;
  int  small_cmds = 0;
  bit  no_gaps = 1'b0;

  ellipse_quadrant_span_fill dut (.*);

  span_word_checker span_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 5);
    return $urandom_range(20, 120);
  endfunction

  task automatic issue_cmd(input logic [1:0] c, input int ax, input int ay,
                           input int rx, input int ry);
    int gap;
    start    <= 1'b1;
    corner   <= c;
    anchor_x <= 10'(ax);
    anchor_y <= 10'(ay);
    radius_x <= 5'(rx);
    radius_y <= 5'(ry);
    do @(posedge clk); while (busy);
    cmds_sent++;
    if (rx < 2 || ry < 2)
      small_cmds++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int ax, ay, rx, ry;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // small radii, then the largest and the smallest full radii in each corner
    issue_cmd(2'd0, 64, 32, 0, 0);
    issue_cmd(2'd1, 64, 32, 1, 31);
    issue_cmd(2'd2, 64, 32, 31, 1);
    issue_cmd(2'd3, 10, 10, 0, 2);
    issue_cmd(2'd0, 10, 10, 2, 0);
    for (int c = 0; c < 4; c++) begin
      issue_cmd(2'(c), 64, 32, 31, 31);
      issue_cmd(2'(c), 64, 32, 2, 2);
    end
    // clipping at each screen edge
    issue_cmd(2'd1, 0, 20, 20, 10);
    issue_cmd(2'd0, 120, 20, 20, 10);
    issue_cmd(2'd0, 60, 5, 10, 20);
    issue_cmd(2'd2, 60, 60, 10, 20);
    issue_cmd(2'd3, 140, 70, 31, 31);
    issue_cmd(2'd1, 127, 63, 31, 17);
    // anchor extremes, far off screen
    issue_cmd(2'd3, -512, -512, 31, 31);
    issue_cmd(2'd0, 511, 511, 31, 31);
    issue_cmd(2'd1, 511, -512, 31, 2);
    issue_cmd(2'd2, -512, 511, 2, 31);

    for (int i = 0; i < RANDOM_CMDS; i++) begin
      if (i % 50 == 0)
        no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        ax = int'($urandom_range(0, 207)) - 40;
        ay = int'($urandom_range(0, 143)) - 40;
      end else begin
        ax = int'($urandom_range(0, 1023)) - 512;
        ay = int'($urandom_range(0, 1023)) - 512;
      end
      rx = $urandom_range(2, 31);
      ry = $urandom_range(2, 31);
      case ($urandom_range(0, 19))
        0: rx = $urandom_range(0, 1);
        1: ry = $urandom_range(0, 1);
        2: begin
          rx = $urandom_range(2, 6);
          ry = $urandom_range(2, 6);
        end
        default: ;
      endcase
      issue_cmd(2'($urandom_range(0, 3)), ax, ay, rx, ry);
    end
    start <= 1'b0;

    @(posedge clk);
    while (waiting != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("tb: %0d commands over all corners (%0d with a small radius)",
             cmds_sent, small_cmds);
    $display("tb: %0d span words checked, %0d mismatches", words_checked, fails);
    if (fails == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ----- ellipse_quadrant_span_fill.f -----
rtl/eqsf_pkg.sv
rtl/eqsf_seq.sv
rtl/eqsf_dp.sv
rtl/ellipse_quadrant_span_fill.sv
dv/span_word_checker.sv
dv/tb_ellipse_quadrant_span_fill.sv
